// File: rtl/cpr_pkg.sv
// ---------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants for the clock page replacement block.
// ---------------------------------------------------------------------------
package cpr_pkg;

   // width of the frame count register
   localparam int unsigned CFG_W = 4;

   // frame count after reset
   localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd3;

   // fault counter width and saturation value
   localparam int unsigned FAULT_W = 16;
   localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

   // engine sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_SWEEP = 5'b00100,
      ST_EVICT = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // outcome flags of one reference
   typedef struct packed {
      logic hit;
      logic fault;
   } res_flags_type;

endpackage

// File: rtl/cpr_page_ram.sv
// ---------------------------------------------------------------------------
// cpr_page_ram
// Page number store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module cpr_page_ram #(
   parameter int unsigned DEPTH  = 8,
   parameter int unsigned WIDTH  = 16,
   parameter int unsigned ADDR_W = 3
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data appears in the cycle after the read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cpr_engine.sv
// ---------------------------------------------------------------------------
// cpr_engine
// Reference sequencer: scans the page store for a hit, fills an empty frame
// or sweeps the clock hand over the use bits and replaces a frame.
// ---------------------------------------------------------------------------
module cpr_engine #(
   parameter int unsigned MAX_FRAMES = 8,
   parameter int unsigned PAGE_BITS  = 16,
   parameter int unsigned IDX_W      = 3,
   parameter int unsigned CNT_W      = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   // active frame count, already clamped to 1..MAX_FRAMES
   input  logic [CNT_W-1:0]              n_frames,
   // incoming reference
   input  logic                          item_valid,
   output logic                          item_ready,
   input  logic [PAGE_BITS-1:0]          item_page,
   // finished result
   output logic                          res_valid,
   input  logic                          res_take,
   output cpr_pkg::res_flags_type        res_flags,
   output logic [IDX_W-1:0]              res_slot,
   output logic [PAGE_BITS-1:0]          res_evicted,
   output logic [cpr_pkg::FAULT_W-1:0]   res_total,
   // page store port
   output logic                          mem_rd_en,
   output logic [IDX_W-1:0]              mem_rd_addr,
   input  logic [PAGE_BITS-1:0]          mem_rd_data,
   output logic                          mem_wr_en,
   output logic [IDX_W-1:0]              mem_wr_addr,
   output logic [PAGE_BITS-1:0]          mem_wr_data
);
   import cpr_pkg::*;

   state_type            state_ff, state_in;
   logic [PAGE_BITS-1:0] pg_ff, pg_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]     h_ff, h_in;
   logic [IDX_W-1:0]     hand_ff, hand_in;
   logic [FAULT_W-1:0]   fault_cnt_ff, fault_cnt_in;
   logic                 valid_ff [MAX_FRAMES];
   logic                 valid_in [MAX_FRAMES];
   logic                 use_ff [MAX_FRAMES];
   logic                 use_in [MAX_FRAMES];
   res_flags_type        flags_ff, flags_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic [PAGE_BITS-1:0] evict_ff, evict_in;

   logic                 hit_now;
   logic                 empty_found;
   logic [IDX_W-1:0]     empty_idx;
   logic [IDX_W-1:0]     h_next;
   logic [IDX_W-1:0]     h_start;

   // lowest empty frame among the active ones
   always_comb begin
      empty_found = 1'b0;
      empty_idx   = '0;
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if ((CNT_W'(i) < n_frames) && !valid_ff[i]) begin
            empty_found = 1'b1;
            empty_idx   = IDX_W'(i);
         end
      end
   end

   // compare of the entry read in the previous cycle
   assign hit_now = pend_ff && valid_ff[pend_idx_ff] && (mem_rd_data == pg_ff);

   // hand step with wrap at the active count
   assign h_next = ((CNT_W'(h_ff) + CNT_W'(1)) == n_frames) ? '0 : h_ff + IDX_W'(1);

   // sweep start, frame zero when the hand lies outside the active frames
   assign h_start = (CNT_W'(hand_ff) < n_frames) ? hand_ff : '0;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pg_in        = pg_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      h_in         = h_ff;
      hand_in      = hand_ff;
      fault_cnt_in = fault_cnt_ff;
      valid_in     = valid_ff;
      use_in       = use_ff;
      flags_in     = flags_ff;
      slot_in      = slot_ff;
      evict_in     = evict_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = '0;
      mem_wr_data  = pg_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               pg_in    = item_page;
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (hit_now) begin
               use_in[pend_idx_ff] = 1'b1;
               flags_in = '{hit: 1'b1, fault: 1'b0};
               slot_in  = pend_idx_ff;
               evict_in = '0;
               state_in = ST_DONE;
            end else if (idx_ff < n_frames) begin
               // issue the next entry read
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff[IDX_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[IDX_W-1:0];
               idx_in      = idx_ff + CNT_W'(1);
            end else if (empty_found) begin
               // miss with a free frame: fill without fault
               mem_wr_en   = 1'b1;
               mem_wr_addr = empty_idx;
               valid_in[empty_idx] = 1'b1;
               use_in[empty_idx]   = 1'b1;
               flags_in = '{hit: 1'b0, fault: 1'b0};
               slot_in  = empty_idx;
               evict_in = '0;
               state_in = ST_DONE;
            end else begin
               h_in     = h_start;
               state_in = ST_SWEEP;
            end
         end

         ST_SWEEP: begin
            if (use_ff[h_ff]) begin
               // second chance: clear and move on
               use_in[h_ff] = 1'b0;
               h_in         = h_next;
            end else begin
               // victim found, fetch its page
               mem_rd_en   = 1'b1;
               mem_rd_addr = h_ff;
               state_in    = ST_EVICT;
            end
         end

         ST_EVICT: begin
            mem_wr_en    = 1'b1;
            mem_wr_addr  = h_ff;
            use_in[h_ff] = 1'b1;
            flags_in     = '{hit: 1'b0, fault: 1'b1};
            slot_in      = h_ff;
            evict_in     = mem_rd_data;
            hand_in      = h_next;
            if (fault_cnt_ff != FAULT_MAX) begin
               fault_cnt_in = fault_cnt_ff + FAULT_W'(1);
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         hand_ff      <= '0;
         fault_cnt_ff <= '0;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            valid_ff[i] <= 1'b0;
            use_ff[i]   <= 1'b1;
         end
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         hand_ff      <= hand_in;
         fault_cnt_ff <= fault_cnt_in;
         valid_ff     <= valid_in;
         use_ff       <= use_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      pg_ff       <= pg_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      h_ff        <= h_in;
      flags_ff    <= flags_in;
      slot_ff     <= slot_in;
      evict_ff    <= evict_in;
   end

   assign item_ready  = (state_ff == ST_IDLE);
   assign res_valid   = (state_ff == ST_DONE);
   assign res_flags   = flags_ff;
   assign res_slot    = slot_ff;
   assign res_evicted = evict_ff;
   assign res_total   = fault_cnt_ff;

endmodule

// File: rtl/clock_page_replacement.sv
// ---------------------------------------------------------------------------
// clock_page_replacement
// Clock (second chance) page replacement over a small set of frames.
//
//   channel  direction  ports
//   req      in         req_valid, req_ready, req_page
//   rsp      out        rsp_valid, rsp_ready, rsp_hit, rsp_fault, rsp_slot,
//                       rsp_evicted_page, rsp_fault_total
//   csr      in         csr_valid, csr_ready, csr_frames_in_use
//
// An item with n active frames is scanned one page store read per cycle;
// a miss with no empty frame then sweeps the clock hand one step at a time,
// clearing use bits, and ends with an eviction step that reads the victim.
// The single page store read port sets this pace.
// The output register holds a result while the next item is taken.
// Reset is synchronous; the frame count returns to 3, all frames empty.
// ---------------------------------------------------------------------------
module clock_page_replacement #(
   parameter int unsigned MAX_FRAMES = 8,
   parameter int unsigned PAGE_BITS  = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // reference input
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic [PAGE_BITS-1:0]                        req_page,
   // result output
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic                                        rsp_hit,
   output logic                                        rsp_fault,
   output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] rsp_slot,
   output logic [PAGE_BITS-1:0]                        rsp_evicted_page,
   output logic [cpr_pkg::FAULT_W-1:0]                 rsp_fault_total,
   // frame count register write
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [cpr_pkg::CFG_W-1:0]                   csr_frames_in_use
);
   import cpr_pkg::*;

   localparam int unsigned IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);

   logic [CFG_W-1:0]     frames_ff, frames_in;
   logic [CNT_W-1:0]     n_frames;

   logic                 eng_res_valid;
   logic                 eng_res_take;
   res_flags_type        eng_flags;
   logic [IDX_W-1:0]     eng_slot;
   logic [PAGE_BITS-1:0] eng_evicted;
   logic [FAULT_W-1:0]   eng_total;

   logic                 mem_rd_en;
   logic [IDX_W-1:0]     mem_rd_addr;
   logic [PAGE_BITS-1:0] mem_rd_data;
   logic                 mem_wr_en;
   logic [IDX_W-1:0]     mem_wr_addr;
   logic [PAGE_BITS-1:0] mem_wr_data;

   logic                 out_valid_ff, out_valid_in;
   res_flags_type        out_flags_ff;
   logic [IDX_W-1:0]     out_slot_ff;
   logic [PAGE_BITS-1:0] out_evicted_ff;
   logic [FAULT_W-1:0]   out_total_ff;

   // frame count register
   assign csr_ready = 1'b1;
   assign frames_in = (csr_valid && csr_ready) ? csr_frames_in_use : frames_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_RESET;
      end else begin
         frames_ff <= frames_in;
      end
   end

   // clamp the count into 1..MAX_FRAMES
   always_comb begin
      priority if (frames_ff == '0) begin
         n_frames = CNT_W'(1);
      end else if (32'(frames_ff) > MAX_FRAMES) begin
         n_frames = CNT_W'(MAX_FRAMES);
      end else begin
         n_frames = CNT_W'(frames_ff);
      end
   end

   // page store
   cpr_page_ram #(
      .DEPTH  (MAX_FRAMES),
      .WIDTH  (PAGE_BITS),
      .ADDR_W (IDX_W)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // reference sequencer
   cpr_engine #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .n_frames    (n_frames),
      .item_valid  (req_valid),
      .item_ready  (req_ready),
      .item_page   (req_page),
      .res_valid   (eng_res_valid),
      .res_take    (eng_res_take),
      .res_flags   (eng_flags),
      .res_slot    (eng_slot),
      .res_evicted (eng_evicted),
      .res_total   (eng_total),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   // output register, loads when empty or being drained
   assign eng_res_take = eng_res_valid && (!out_valid_ff || rsp_ready);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (eng_res_take) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_res_take) begin
         out_flags_ff   <= eng_flags;
         out_slot_ff    <= eng_slot;
         out_evicted_ff <= eng_evicted;
         out_total_ff   <= eng_total;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_hit          = out_flags_ff.hit;
   assign rsp_fault        = out_flags_ff.fault;
   assign rsp_slot         = out_slot_ff;
   assign rsp_evicted_page = out_evicted_ff;
   assign rsp_fault_total  = out_total_ff;

`ifndef NO_ASSERTIONS
   // an accepted item keeps the engine busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("engine ready right after accepting an item");

   // a result is never both a hit and a fault
   a_hit_fault_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_fault))
      else $error("result flagged as hit and fault");

   // a finished result blocked by a full output register is kept
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (eng_res_valid && !eng_res_take) |=> eng_res_valid)
      else $error("engine result dropped while output register full");

   // a non-fault result carries no evicted page
   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fault) |-> (rsp_evicted_page == '0))
      else $error("evicted page set without a fault");
`endif

endmodule

// File: tb/cpr_outcome_checker.sv
// ---------------------------------------------------------------------------
// cpr_outcome_checker
// Watches the page reference, result and frame count channels of the clock
// page replacement block. Each accepted page reference is run through a
// local copy of the frame table, use bits and clock hand. The outcome is
// queued, and every accepted result is compared field by field with the
// oldest queued outcome.
// ---------------------------------------------------------------------------
module cpr_outcome_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [15:0]                 req_page,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_hit,
   input  logic                        rsp_fault,
   input  logic [2:0]                  rsp_slot,
   input  logic [15:0]                 rsp_evicted_page,
   input  logic [cpr_pkg::FAULT_W-1:0] rsp_fault_total,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [cpr_pkg::CFG_W-1:0]   csr_frames_in_use,
   output int                          mismatch_count,
   output int                          results_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import cpr_pkg::*;

   localparam int unsigned FRAME_SLOTS = 8;

   // one predicted result
   typedef struct packed {
      res_flags_type      flags;
      logic [2:0]         slot;
      logic [15:0]        evicted_page;
      logic [FAULT_W-1:0] fault_total;
   } page_outcome_type;

   // local frame table and clock hand
   logic [15:0]        frame_page [FRAME_SLOTS];
   logic               frame_valid [FRAME_SLOTS];
   logic               use_mark [FRAME_SLOTS];
   int unsigned        hand_pos;
   logic [FAULT_W-1:0] faults_seen;
   logic [CFG_W-1:0]   frames_cfg;

   page_outcome_type   outcome_queue [$];

   initial mismatch_count = 0;
   initial results_pending = 0;

   // out-of-range counts clamp to one and to the built frame count
   function automatic int unsigned active_frames();
      if (frames_cfg == '0)
         return 1;
      if (frames_cfg > FRAME_SLOTS)
         return FRAME_SLOTS;
      return frames_cfg;
   endfunction

   // apply one page reference to the frame table, return its outcome
   function automatic page_outcome_type resolve_reference(input logic [15:0] pg);
      page_outcome_type res;
      int unsigned      n;
      int unsigned      h;
      int unsigned      k;
      logic             placed;
      res = '0;
      n = active_frames();
      placed = 1'b0;
      // hit in an active frame
      for (k = 0; k < n && !placed; k++) begin
         if (frame_valid[k] && frame_page[k] == pg) begin
            use_mark[k] = 1'b1;
            res.slot = k[2:0];
            res.flags.hit = 1'b1;
            placed = 1'b1;
         end
      end
      // fill the lowest empty active frame
      for (k = 0; k < n && !placed; k++) begin
         if (!frame_valid[k]) begin
            frame_page[k] = pg;
            frame_valid[k] = 1'b1;
            use_mark[k] = 1'b1;
            res.slot = k[2:0];
            placed = 1'b1;
         end
      end
      // second chance sweep from the hand, restarting at zero if out of range
      if (!placed) begin
         h = (hand_pos < n) ? hand_pos : 0;
         for (k = 0; k <= 2 * n && !placed; k++) begin
            if (!use_mark[h]) begin
               res.evicted_page = frame_page[h];
               frame_page[h] = pg;
               use_mark[h] = 1'b1;
               res.slot = h[2:0];
               res.flags.fault = 1'b1;
               if (faults_seen != FAULT_MAX)
                  faults_seen = faults_seen + 1'b1;
               placed = 1'b1;
            end else begin
               use_mark[h] = 1'b0;
            end
            h = (h + 1) % n;
         end
         hand_pos = h;
      end
      res.fault_total = faults_seen;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // sample all three channels at each edge
   always @(posedge clock) begin
      page_outcome_type want;
      int unsigned      k;
      if (reset) begin
         for (k = 0; k < FRAME_SLOTS; k++) begin
            frame_page[k] = '0;
            frame_valid[k] = 1'b0;
            use_mark[k] = 1'b1;
         end
         hand_pos = 0;
         faults_seen = '0;
         frames_cfg = FRAMES_RESET;
         outcome_queue.delete();
      end else begin
         if (csr_valid && csr_ready)
            frames_cfg = csr_frames_in_use;
         // compare a returned item with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (outcome_queue.size() == 0) begin
               $error("result item with no page reference outstanding");
               mismatch_count++;
            end else begin
               want = outcome_queue.pop_front();
               check_field("rsp_hit", 16'(want.flags.hit), 16'(rsp_hit));
               check_field("rsp_fault", 16'(want.flags.fault), 16'(rsp_fault));
               check_field("rsp_slot", 16'(want.slot), 16'(rsp_slot));
               check_field("rsp_evicted_page", want.evicted_page, rsp_evicted_page);
               check_field("rsp_fault_total", want.fault_total, rsp_fault_total);
            end
         end
         if (req_valid && req_ready)
            outcome_queue.push_back(resolve_reference(req_page));
      end
      results_pending <= outcome_queue.size();
   end

endmodule

// File: tb/clock_page_replacement_test.sv
// ---------------------------------------------------------------------------
// clock_page_replacement_test
// Stimulus and verdict for the clock page replacement block. A directed run
// covers page extremes, hits, fills, faults and the frame count corner
// cases; random runs then work on small page pools under several frame
// counts and idle patterns, with one long result stall. Checking is done by
// the cpr_outcome_checker instance.
// ---------------------------------------------------------------------------
module clock_page_replacement_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cpr_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [15:0]        req_page = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_hit;
   logic               rsp_fault;
   logic [2:0]         rsp_slot;
   logic [15:0]        rsp_evicted_page;
   logic [FAULT_W-1:0] rsp_fault_total;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CFG_W-1:0]   csr_frames_in_use = '0;

   int                 mismatch_count;
   int                 results_pending;

   // idle odds in percent, and a requested result hold-off in cycles
   int unsigned        send_idle = 0;
   int unsigned        recv_idle = 0;
   int unsigned        hold_request = 0;

   // working set of pages for random references
   logic [15:0]        page_pool [16];
   int unsigned        pool_size = 4;

   clock_page_replacement #(
      .MAX_FRAMES (8),
      .PAGE_BITS  (16)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page          (req_page),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_fault         (rsp_fault),
      .rsp_slot          (rsp_slot),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_frames_in_use (csr_frames_in_use)
   );

   cpr_outcome_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page          (req_page),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_fault         (rsp_fault),
      .rsp_slot          (rsp_slot),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_frames_in_use (csr_frames_in_use),
      .mismatch_count    (mismatch_count),
      .results_pending   (results_pending)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stalls, or a long hold-off when requested
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // offer one page reference, with a random gap first
   task automatic send_page(input logic [15:0] pg);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_page <= pg;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait until every item has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0)
         @(posedge clock);
   endtask

   task automatic write_frames(input logic [CFG_W-1:0] count);
      csr_valid <= 1'b1;
      csr_frames_in_use <= count;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // mostly pool pages so hits and sweeps happen, sometimes any page
   function automatic logic [15:0] next_page();
      if ($urandom_range(99) < 85)
         return page_pool[$urandom_range(0, pool_size - 1)];
      return 16'($urandom);
   endfunction

   // new frame count and working set, then a run of references
   task automatic run_segment(input int unsigned count);
      int unsigned k;
      write_frames(4'($urandom_range(0, 15)));
      for (k = 0; k < 16; k++)
         page_pool[k] = 16'($urandom);
      pool_size = $urandom_range(1, 16);
      for (k = 0; k < count; k++)
         send_page(next_page());
      wait_drained();
   endtask

   initial begin
      int unsigned k;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: three frames after reset, fills, hits, full sweep
      send_idle = 28;
      recv_idle = 86;
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'h0000);
      send_page(16'h8001);
      send_page(16'hFFFF);
      send_page(16'h7FFE);
      send_page(16'h0000);
      wait_drained();
      // shrink to one frame with the hand past it
      write_frames(4'd1);
      send_page(16'h1111);
      send_page(16'h1111);
      wait_drained();
      // zero acts as one frame
      write_frames(4'd0);
      send_page(16'h2222);
      wait_drained();
      // above range acts as eight; old frames rejoin
      write_frames(4'd15);
      send_page(16'h0000);
      send_page(16'h3333);
      send_page(16'h4444);
      send_page(16'h5555);
      send_page(16'h6666);
      send_page(16'h7777);
      send_page(16'h9999);
      wait_drained();
      write_frames(4'd8);
      send_page(16'hAAAA);
      send_page(16'h5555);
      send_page(16'hFFFF);
      wait_drained();

      // random: slow sender, slower receiver
      send_idle = 28;
      recv_idle = 86;
      for (k = 0; k < 3; k++)
         run_segment(90);
      // random: roles swapped
      send_idle = 86;
      recv_idle = 28;
      for (k = 0; k < 3; k++)
         run_segment(90);
      // random: no idling, one long result stall to back up the input
      send_idle = 0;
      recv_idle = 0;
      hold_request = 300;
      run_segment(40);
      for (k = 0; k < 3; k++)
         run_segment(75);

      repeat (30) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: files.f
rtl/cpr_pkg.sv
rtl/cpr_page_ram.sv
rtl/cpr_engine.sv
rtl/clock_page_replacement.sv
tb/cpr_outcome_checker.sv
tb/clock_page_replacement_test.sv
